/* rtl/tcw_pkg.sv */
package tcw_pkg;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELL_COUNT = ROWS * COLS;

    localparam int CELL_W = 11;
    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int WORD_W = 16;

    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);
    localparam logic [CELL_W-1:0] TAIL_START = CELL_W'(CELL_COUNT - COLS);
    localparam logic [CELL_W-1:0] COPY_LAST = CELL_W'(CELL_COUNT - COLS - 1);
    localparam logic [CELL_W-1:0] ROW_STEP = CELL_W'(COLS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    localparam logic [COLOR_W-1:0] FORE_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BACK_RESET = 4'd0;

    localparam logic CFG_FORE = 1'b0;
    localparam logic CFG_BACK = 1'b1;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef struct packed {
        logic latch;
        logic put;
        logic rd_cell;
        logic cnt_zero;
        logic cnt_tail;
        logic copy;
        logic fill;
        logic reply;
        logic read_reply;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic wrap;
        logic copy_last;
        logic fill_last;
    } t_status;

endpackage

/* rtl/tcw_ctrl.sv */
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_status.req)
                    REQ_PUT: begin
                        o_cmd.put = 1'b1;
                        if (i_status.wrap) begin
                            o_cmd.cnt_zero = 1'b1;
                            n_state = ST_COPY;
                        end else begin
                            o_cmd.reply = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.cnt_zero = 1'b1;
                        n_state = ST_FILL;
                    end
                    REQ_READ: begin
                        o_cmd.rd_cell = 1'b1;
                        n_state = ST_RD_WAIT;
                    end
                    default: begin
                        o_cmd.reply = 1'b1;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RD_WAIT: begin
                o_cmd.reply = 1'b1;
                o_cmd.read_reply = 1'b1;
                n_state = ST_IDLE;
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_status.copy_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.cnt_tail = 1'b1;
                n_state = ST_FILL;
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.reply = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy <= (n_state != ST_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

/* rtl/tcw_datapath.sv */
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_req_type,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [CELL_W-1:0]  i_cell_index,
    input  logic               i_last_of_write,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [COLOR_W-1:0] i_cfg_data,
    output logic               o_done,
    output logic [CELL_W-1:0]  o_cursor_pos,
    output logic               o_cursor_load,
    output logic [WORD_W-1:0]  o_read_cell
);

    t_req               r_req;
    logic [CHAR_W-1:0]  r_ch;
    logic [CELL_W-1:0]  r_idx;
    logic               r_in_rng;
    logic               r_last;

    logic [COLOR_W-1:0] r_fore, r_back;
    logic [CELL_W-1:0]  r_lin, n_lin;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [CELL_W-1:0]  r_cnt;

    logic [WORD_W-1:0]  r_mem [CELL_COUNT];
    logic [WORD_W-1:0]  r_rdata;
    logic               r_copy_pend;
    logic [CELL_W-1:0]  r_copy_addr;

    logic               r_done, r_load;
    logic [CELL_W-1:0]  r_pos;
    logic [WORD_W-1:0]  r_cell;

    logic               newline, wrap;
    logic [7:0]         attr;
    logic               mem_we, mem_re;
    logic [CELL_W-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0]  mem_wdata;

    assign attr = {r_back, r_fore};
    assign newline = (r_ch == NEWLINE_CHAR);
    assign wrap = (r_row == ROW_LAST) && (newline || (r_col == COL_LAST));

    assign o_status.req = r_req;
    assign o_status.wrap = wrap;
    assign o_status.copy_last = (r_cnt == COPY_LAST);
    assign o_status.fill_last = (r_cnt == CELL_LAST);

    // cursor advance
    always_comb begin
        n_lin = r_lin;
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.put) begin
            if (wrap) begin
                n_lin = TAIL_START;
                n_col = '0;
                n_row = ROW_LAST;
            end else if (newline) begin
                n_lin = r_lin - CELL_W'(r_col) + ROW_STEP;
                n_col = '0;
                n_row = r_row + 1'b1;
            end else if (r_col == COL_LAST) begin
                n_lin = r_lin + 1'b1;
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_lin = r_lin + 1'b1;
                n_col = r_col + 1'b1;
            end
        end
    end

    // single write port, single read port
    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_lin;
        mem_wdata = {attr, r_ch};
        if (r_copy_pend) begin
            mem_we = 1'b1;
            mem_waddr = r_copy_addr;
            mem_wdata = r_rdata;
        end else if (i_cmd.fill) begin
            mem_we = 1'b1;
            mem_waddr = r_cnt;
            mem_wdata = {attr, SPACE_CHAR};
        end else if (i_cmd.put && !newline) begin
            mem_we = 1'b1;
        end
        mem_re = i_cmd.copy || (i_cmd.rd_cell && r_in_rng);
        mem_raddr = i_cmd.copy ? (r_cnt + ROW_STEP) : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
        r_copy_addr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= t_req'(i_req_type);
            r_ch <= i_char_code;
            r_idx <= i_cell_index;
            r_in_rng <= (i_cell_index <= CELL_LAST);
            r_last <= i_last_of_write;
        end
        if (i_cmd.reply) begin
            r_pos <= n_lin;
            r_load <= (r_req == REQ_PUT) && r_last;
            r_cell <= (i_cmd.read_reply && r_in_rng) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore <= FORE_RESET;
            r_back <= BACK_RESET;
            r_lin <= '0;
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
            r_copy_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FORE: r_fore <= i_cfg_data;
                    CFG_BACK: r_back <= i_cfg_data;
                    default: ;
                endcase
            end
            r_lin <= n_lin;
            r_col <= n_col;
            r_row <= n_row;
            priority if (i_cmd.cnt_zero) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_tail) begin
                r_cnt <= TAIL_START;
            end else if (i_cmd.copy || i_cmd.fill) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_copy_pend <= i_cmd.copy;
            r_done <= i_cmd.reply;
        end
    end

    assign o_done = r_done;
    assign o_cursor_pos = r_pos;
    assign o_cursor_load = r_load;
    assign o_read_cell = r_cell;

endmodule

/* rtl/text_console_writer_unit.sv */
// Text console writer: screen store of ROWS x COLS cells, {attribute, character}.
// Requests: pulse start with the item fields while busy is low; the item is
// taken on that edge and busy is high from that edge on. Each item yields one
// result, shown for one cycle with o_done high: cursor position, cursor-load
// flag and, for a read, the cell contents. The receiver cannot stall; the
// result is simply presented for that one cycle.
// Processing, one item at a time (busy stays high until the result):
//   put character without scroll, unused code: result straight from execute
//   read cell: one registered memory read, then the result
//   clear: every cell blanked in turn, one cell written per cycle
//   put that scrolls: rows copied up through the single read port and
//     single write port, a drain step, then the bottom row is blanked
// Colors are written over the config channel (index 0 fore, 1 back), which
// is always ready; write them only while the block is idle.
// Reset (synchronous, active low): cursor to 0, fore 15, back 0, idle. The
// screen store is not cleared; issue a clear before reading cells.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [CELL_W-1:0]  i_cell_index,
    input  logic               i_last_of_write,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [COLOR_W-1:0] i_cfg_data,
    output logic               o_done,
    output logic [CELL_W-1:0]  o_cursor_pos,
    output logic               o_cursor_load,
    output logic [WORD_W-1:0]  o_read_cell
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_last_of_write (i_last_of_write),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_cursor_pos    (o_cursor_pos),
        .o_cursor_load   (o_cursor_load),
        .o_read_cell     (o_read_cell)
    );

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but busy did not rise");

    a_cursor_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cursor_pos <= CELL_LAST))
        else $error("cursor outside screen store");

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES = 6;
    localparam int PHASE_ITEMS = 255;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int TAIL_CYCLES = CELL_COUNT + 8;

    typedef struct packed {
        logic [CELL_W-1:0] pos;
        logic              load;
        logic [WORD_W-1:0] rd_word;
    } t_report;

    typedef struct {
        logic [1:0]        req;
        logic [CHAR_W-1:0] ch;
        logic [CELL_W-1:0] idx;
        logic              last;
        bit                typed;
        t_report           want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = REQ_PUT;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [CELL_W-1:0]  i_cell_index = '0;
    logic               i_last_of_write = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_FORE;
    logic [COLOR_W-1:0] i_cfg_data = '0;
    logic               o_done;
    logic [CELL_W-1:0]  o_cursor_pos;
    logic               o_cursor_load;
    logic [WORD_W-1:0]  o_read_cell;

    // console model state
    logic [WORD_W-1:0]  screen_copy [CELL_COUNT];
    int                 cursor_at = 0;
    logic [COLOR_W-1:0] fore_now = FORE_RESET;
    logic [COLOR_W-1:0] back_now = BACK_RESET;

    t_report            pending_reports [$];
    t_report            pinned_report = '0;
    bit                 pinned = 1'b0;
    bit                 steady_run = 1'b0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    t_stim_row          directed_rows [N_DIRECTED];

    text_console_writer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_last_of_write (i_last_of_write),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_cursor_pos    (o_cursor_pos),
        .o_cursor_load   (o_cursor_load),
        .o_read_cell     (o_read_cell)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_report console_advance(input logic [1:0] req,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic [CELL_W-1:0] idx,
                                                input logic last);
        t_report             rep;
        logic [COLOR_W*2-1:0] attr;
        rep = '0;
        attr = {back_now, fore_now};
        case (req)
            REQ_PUT: begin
                if (ch == NEWLINE_CHAR) begin
                    cursor_at = (cursor_at / COLS + 1) * COLS;
                end else begin
                    if (cursor_at < CELL_COUNT) screen_copy[cursor_at] = {attr, ch};
                    cursor_at++;
                end
                if (cursor_at >= CELL_COUNT) begin
                    for (int i = 0; i < CELL_COUNT - COLS; i++)
                        screen_copy[i] = screen_copy[i + COLS];
                    for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                        screen_copy[i] = {attr, SPACE_CHAR};
                    cursor_at = CELL_COUNT - COLS;
                end
                rep.load = last;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {attr, SPACE_CHAR};
            end
            REQ_READ: begin
                if (idx < CELL_COUNT) rep.rd_word = screen_copy[idx];
            end
            default: ;
        endcase
        rep.pos = CELL_W'(cursor_at);
        return rep;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_report want;
        t_report seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FORE) fore_now = i_cfg_data;
                else back_now = i_cfg_data;
            end
            if (start && !busy) begin
                want = console_advance(i_req_type, i_char_code, i_cell_index, i_last_of_write);
                pending_reports.push_back(pinned ? pinned_report : want);
            end
            if (o_done) begin
                seen = '{o_cursor_pos, o_cursor_load, o_read_cell};
                if (pending_reports.size() == 0) begin
                    $error("result with no item pending: cursor_pos %0d", seen.pos);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (seen.pos !== want.pos) begin
                        $error("cursor_pos: expected %0d, got %0d", want.pos, seen.pos);
                        mismatches++;
                    end
                    if (seen.load !== want.load) begin
                        $error("cursor_load: expected %0d, got %0d", want.load, seen.load);
                        mismatches++;
                    end
                    if (seen.rd_word !== want.rd_word) begin
                        $error("read_cell: expected %h, got %h", want.rd_word, seen.rd_word);
                        mismatches++;
                    end
                end
            end
        end
        quiet_cycles <= (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready)) ?
                        0 : quiet_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic issue(input logic [1:0] req, input logic [CHAR_W-1:0] ch,
                         input logic [CELL_W-1:0] idx, input logic last,
                         input bit typed, input t_report want);
        int gap;
        if ($urandom_range(0, 39) == 0) steady_run = !steady_run;
        gap = steady_run ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type = req;
        i_char_code = ch;
        i_cell_index = idx;
        i_last_of_write = last;
        pinned = typed;
        pinned_report = want;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic settle();
        start = 1'b0;
        while (pending_reports.size() != 0 || busy) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_color(input logic idx, input logic [COLOR_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int                 kind;
        int                 len;
        int                 pick;
        int                 counted;
        bit                 broken;
        logic [1:0]         req;
        logic [CHAR_W-1:0]  ch;
        logic [CELL_W-1:0]  idx;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;

        // default colors: attribute 0x0F, blank cell 0x0F20
        directed_rows = '{
            '{REQ_PUT,   8'h41, 11'd0,    1'b1, 1'b1, '{11'd1,   1'b1, 16'h0000}},
            '{REQ_CLEAR, 8'h00, 11'd0,    1'b1, 1'b1, '{11'd1,   1'b0, 16'h0000}},
            '{REQ_READ,  8'h00, 11'd0,    1'b0, 1'b1, '{11'd1,   1'b0, 16'h0F20}},
            '{REQ_READ,  8'h00, 11'd1999, 1'b1, 1'b1, '{11'd1,   1'b0, 16'h0F20}},
            '{REQ_READ,  8'h00, 11'd2000, 1'b0, 1'b1, '{11'd1,   1'b0, 16'h0000}},
            '{REQ_READ,  8'hFF, 11'd2047, 1'b1, 1'b1, '{11'd1,   1'b0, 16'h0000}},
            '{REQ_SPARE, 8'hFF, 11'd2047, 1'b1, 1'b1, '{11'd1,   1'b0, 16'h0000}},
            '{REQ_PUT,   8'h00, 11'd0,    1'b0, 1'b1, '{11'd2,   1'b0, 16'h0000}},
            '{REQ_PUT,   8'hFF, 11'd2047, 1'b1, 1'b1, '{11'd3,   1'b1, 16'h0000}},
            '{REQ_READ,  8'h00, 11'd1,    1'b0, 1'b1, '{11'd3,   1'b0, 16'h0F00}},
            '{REQ_READ,  8'h00, 11'd2,    1'b0, 1'b1, '{11'd3,   1'b0, 16'h0FFF}},
            '{REQ_PUT,   8'h0A, 11'd0,    1'b1, 1'b1, '{11'd80,  1'b1, 16'h0000}},
            '{REQ_PUT,   8'h0A, 11'd0,    1'b0, 1'b1, '{11'd160, 1'b0, 16'h0000}},
            '{REQ_PUT,   8'h80, 11'd0,    1'b0, 1'b1, '{11'd161, 1'b0, 16'h0000}},
            '{REQ_READ,  8'h00, 11'd160,  1'b0, 1'b1, '{11'd161, 1'b0, 16'h0F80}},
            '{REQ_PUT,   8'h48, 11'd5,    1'b0, 1'b0, '0},
            '{REQ_PUT,   8'h69, 11'd0,    1'b1, 1'b0, '0},
            '{REQ_PUT,   8'h7F, 11'd0,    1'b0, 1'b0, '0},
            '{REQ_PUT,   8'h0A, 11'd0,    1'b0, 1'b0, '0},
            '{REQ_READ,  8'h00, 11'd162,  1'b0, 1'b0, '0},
            '{REQ_READ,  8'h00, 11'd0,    1'b0, 1'b0, '0},
            '{REQ_CLEAR, 8'h20, 11'd1024, 1'b0, 1'b0, '0}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            issue(directed_rows[r].req, directed_rows[r].ch, directed_rows[r].idx,
                  directed_rows[r].last, directed_rows[r].typed, directed_rows[r].want);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: begin fg = 4'd0;  bg = 4'd0;  end
                1: begin fg = 4'd15; bg = 4'd15; end
                2: begin fg = 4'd0;  bg = 4'd15; end
                3: begin fg = 4'd15; bg = 4'd0;  end
                default: begin
                    fg = COLOR_W'($urandom());
                    bg = COLOR_W'($urandom());
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_color(CFG_FORE, fg);
                write_color(CFG_BACK, bg);
            end else begin
                write_color(CFG_BACK, bg);
                write_color(CFG_FORE, fg);
            end

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    // one write call; a few have a scrambled end marker
                    len = $urandom_range(1, 24);
                    broken = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < len; k++) begin
                        pick = $urandom_range(0, 15);
                        if (pick == 0) ch = NEWLINE_CHAR;
                        else if (pick < 12) ch = CHAR_W'($urandom_range(32, 126));
                        else ch = CHAR_W'($urandom());
                        issue(REQ_PUT, ch, CELL_W'($urandom()),
                              broken ? 1'($urandom_range(0, 1)) : (k == len - 1), 1'b0, '0);
                    end
                    counted += len;
                end else if (kind < 85) begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0) idx = CELL_W'($urandom_range(CELL_COUNT, 2047));
                    else if (pick < 6) idx = CELL_W'(cursor_at > 0 ? cursor_at - 1 : 0);
                    else idx = CELL_W'($urandom_range(0, CELL_COUNT - 1));
                    issue(REQ_READ, CHAR_W'($urandom()), idx, 1'($urandom_range(0, 1)),
                          1'b0, '0);
                    counted++;
                end else if (kind < 92) begin
                    issue(REQ_SPARE, CHAR_W'($urandom()), CELL_W'($urandom()),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                end else if (kind < 96) begin
                    issue(REQ_CLEAR, CHAR_W'($urandom()), CELL_W'($urandom()),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                    counted++;
                end else begin
                    req = 2'($urandom());
                    issue(req, CHAR_W'($urandom()), CELL_W'($urandom()),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                    if (req != REQ_SPARE) counted++;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_unit.sv
dv/testbench.sv
